// ----- rtl/ccl_pkg.sv -----
// package for the circular linked list pool
// sizes, field structs and codes used by the pool
`timescale 1ns / 1ps
`default_nettype none

package ccl_pkg;

   localparam int NODE_SLOTS     = 64;
   localparam int WORDS_PER_NODE = 32;

   localparam int SLOT_W    = $clog2(NODE_SLOTS);
   localparam int LINK_W    = $clog2(NODE_SLOTS + 1);
   localparam int WIDX_W    = (WORDS_PER_NODE > 1) ? $clog2(WORDS_PER_NODE) : 1;
   localparam int FILL_W    = $clog2(WORDS_PER_NODE + 1);
   localparam int PAY_AW    = SLOT_W + WIDX_W;
   localparam int PAY_DEPTH = NODE_SLOTS * (1 << WIDX_W);

   localparam logic [LINK_W-1:0] NIL = LINK_W'(NODE_SLOTS);

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_DELETE = 2'd1;
   localparam logic [1:0] ACT_READ   = 2'd2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_MISS = 2'd2;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] payload_word;
      logic        final_word;
      logic [5:0]  position;
      logic [4:0]  word_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [6:0]  slot;
      logic [6:0]  count;
      logic [31:0] read_word;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/circular_linked_list_pool.sv -----
// circular doubly linked list over a fixed pool of node slots, with a free list
// depends on ccl_pkg and ccl_ram (payload, next links, prev links)
//
//   channel  ports                      handshake
//   req      start, busy, req_data      beat taken when start and not busy
//   rsp      rsp_valid, rsp_data        one-cycle strobe, one beat per request
//
// insert word: S_INS_POP to open a node, S_INS_WRITE, S_INS_TAIL, S_INS_LINK behind a head
// delete: walk, S_DEL_RD, then S_DEL_FIX and S_DEL_FREE when other nodes stay linked
// read: walk, S_RD_ISSUE, S_RD_DATA; each link of the walk is one next-link RAM read
// the strobe is high in the first cycle with busy low; misses and full never raise busy
// synchronous reset; next links start as a chain through valid bits, no sweep
`timescale 1ns / 1ps
`default_nettype none

module circular_linked_list_pool (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire ccl_pkg::req_type req_data,
   output logic                  rsp_valid,
   output ccl_pkg::rsp_type      rsp_data
);

   import ccl_pkg::*;

   typedef enum logic [11:0] {
      S_IDLE      = 12'b0000_0000_0001,
      S_INS_POP   = 12'b0000_0000_0010,
      S_INS_WRITE = 12'b0000_0000_0100,
      S_INS_TAIL  = 12'b0000_0000_1000,
      S_INS_LINK  = 12'b0000_0001_0000,
      S_WALK      = 12'b0000_0010_0000,
      S_WALK_WAIT = 12'b0000_0100_0000,
      S_DEL_RD    = 12'b0000_1000_0000,
      S_DEL_FIX   = 12'b0001_0000_0000,
      S_DEL_FREE  = 12'b0010_0000_0000,
      S_RD_ISSUE  = 12'b0100_0000_0000,
      S_RD_DATA   = 12'b1000_0000_0000
   } state_type;

   state_type               state_ff, state_in;
   req_type                 req_ff, req_in;
   logic [LINK_W-1:0]       head_ff, head_in;
   logic [LINK_W-1:0]       free_ff, free_in;
   logic [LINK_W-1:0]       count_ff, count_in;
   logic [FILL_W-1:0]       fill_idx_ff, fill_idx_in;
   logic [LINK_W-1:0]       fill_slot_ff, fill_slot_in;
   logic [SLOT_W-1:0]       cur_ff, cur_in;
   logic [5:0]              steps_ff, steps_in;
   logic [SLOT_W-1:0]       tail_ff, tail_in;
   logic [NODE_SLOTS-1:0]   nvalid_ff, nvalid_in;
   logic                    nvld_rd_ff, nvld_rd_in;
   logic [SLOT_W-1:0]       nrd_addr_ff, nrd_addr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic                    nx_we;
   logic [SLOT_W-1:0]       nx_waddr;
   logic [LINK_W-1:0]       nx_wdata;
   logic [SLOT_W-1:0]       nx_raddr;
   logic [LINK_W-1:0]       nx_rdata;
   logic [LINK_W-1:0]       next_val;

   logic                    pv_we;
   logic [SLOT_W-1:0]       pv_waddr;
   logic [LINK_W-1:0]       pv_wdata;
   logic [SLOT_W-1:0]       pv_raddr;
   logic [LINK_W-1:0]       pv_rdata;

   logic                    pay_we;
   logic [PAY_AW-1:0]       pay_waddr;
   logic [PAY_AW-1:0]       pay_raddr;
   logic [31:0]             pay_rdata;

   logic                    done;
   logic [1:0]              done_status;
   logic [LINK_W-1:0]       done_slot;
   logic [31:0]             done_word;
   logic                    walk_miss;

   ccl_ram #(.WIDTH(LINK_W), .DEPTH(NODE_SLOTS)) u_next_ram (
      .clock   (clock),
      .wr_en   (nx_we),
      .wr_addr (nx_waddr),
      .wr_data (nx_wdata),
      .rd_addr (nx_raddr),
      .rd_data (nx_rdata)
   );

   ccl_ram #(.WIDTH(LINK_W), .DEPTH(NODE_SLOTS)) u_prev_ram (
      .clock   (clock),
      .wr_en   (pv_we),
      .wr_addr (pv_waddr),
      .wr_data (pv_wdata),
      .rd_addr (pv_raddr),
      .rd_data (pv_rdata)
   );

   ccl_ram #(.WIDTH(32), .DEPTH(PAY_DEPTH)) u_payload_ram (
      .clock   (clock),
      .wr_en   (pay_we),
      .wr_addr (pay_waddr),
      .wr_data (req_ff.payload_word),
      .rd_addr (pay_raddr),
      .rd_data (pay_rdata)
   );

   // unwritten next links read as the reset chain
   assign next_val  = nvld_rd_ff ? nx_rdata : (LINK_W'(nrd_addr_ff) + LINK_W'(1));
   assign pay_waddr = {fill_slot_ff[SLOT_W-1:0], fill_idx_ff[WIDX_W-1:0]};
   assign pay_raddr = {cur_ff, req_ff.word_index[WIDX_W-1:0]};

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      head_in      = head_ff;
      free_in      = free_ff;
      count_in     = count_ff;
      fill_idx_in  = fill_idx_ff;
      fill_slot_in = fill_slot_ff;
      cur_in       = cur_ff;
      steps_in     = steps_ff;
      tail_in      = tail_ff;
      nx_we        = 1'b0;
      nx_waddr     = cur_ff;
      nx_wdata     = free_ff;
      nx_raddr     = cur_ff;
      pv_we        = 1'b0;
      pv_waddr     = fill_slot_ff[SLOT_W-1:0];
      pv_wdata     = fill_slot_ff;
      pv_raddr     = cur_ff;
      pay_we       = 1'b0;
      done         = 1'b0;
      done_status  = ST_OK;
      done_slot    = NIL;
      done_word    = 32'd0;
      walk_miss    = ({1'b0, req_data.position} >= count_ff) || (head_ff == NIL);

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               unique case (req_data.action)
                  ACT_INSERT: begin
                     if (fill_slot_ff == NIL) begin
                        if (free_ff == NIL) begin
                           done        = 1'b1;
                           done_status = ST_FULL;
                        end else begin
                           nx_raddr     = free_ff[SLOT_W-1:0];
                           fill_slot_in = free_ff;
                           state_in     = S_INS_POP;
                        end
                     end else begin
                        state_in = S_INS_WRITE;
                     end
                  end
                  ACT_DELETE: begin
                     if (walk_miss) begin
                        done        = 1'b1;
                        done_status = ST_MISS;
                     end else begin
                        cur_in   = head_ff[SLOT_W-1:0];
                        steps_in = req_data.position;
                        state_in = S_WALK;
                     end
                  end
                  ACT_READ: begin
                     if (walk_miss || (int'(req_data.word_index) >= WORDS_PER_NODE)) begin
                        done        = 1'b1;
                        done_status = ST_MISS;
                     end else begin
                        cur_in   = head_ff[SLOT_W-1:0];
                        steps_in = req_data.position;
                        state_in = S_WALK;
                     end
                  end
                  default: begin
                     done        = 1'b1;
                     done_status = ST_MISS;
                  end
               endcase
            end
         end
         S_INS_POP: begin
            free_in     = next_val;
            fill_idx_in = '0;
            state_in    = S_INS_WRITE;
         end
         S_INS_WRITE: begin
            if (fill_idx_ff < FILL_W'(WORDS_PER_NODE)) begin
               pay_we      = 1'b1;
               fill_idx_in = fill_idx_ff + FILL_W'(1);
            end
            if (!req_ff.final_word) begin
               done      = 1'b1;
               done_slot = fill_slot_ff;
               state_in  = S_IDLE;
            end else if (head_ff == NIL) begin
               head_in      = fill_slot_ff;
               pv_we        = 1'b1;
               nx_we        = 1'b1;
               nx_waddr     = fill_slot_ff[SLOT_W-1:0];
               nx_wdata     = fill_slot_ff;
               count_in     = count_ff + LINK_W'(1);
               fill_slot_in = NIL;
               fill_idx_in  = '0;
               done         = 1'b1;
               done_slot    = fill_slot_ff;
               state_in     = S_IDLE;
            end else begin
               pv_raddr = head_ff[SLOT_W-1:0];
               state_in = S_INS_TAIL;
            end
         end
         S_INS_TAIL: begin
            tail_in  = pv_rdata[SLOT_W-1:0];
            pv_we    = 1'b1;
            pv_wdata = pv_rdata;
            nx_we    = 1'b1;
            nx_waddr = fill_slot_ff[SLOT_W-1:0];
            nx_wdata = head_ff;
            state_in = S_INS_LINK;
         end
         S_INS_LINK: begin
            nx_we        = 1'b1;
            nx_waddr     = tail_ff;
            nx_wdata     = fill_slot_ff;
            pv_we        = 1'b1;
            pv_waddr     = head_ff[SLOT_W-1:0];
            pv_wdata     = fill_slot_ff;
            count_in     = count_ff + LINK_W'(1);
            fill_slot_in = NIL;
            fill_idx_in  = '0;
            done         = 1'b1;
            done_slot    = fill_slot_ff;
            state_in     = S_IDLE;
         end
         S_WALK: begin
            if (steps_ff == 6'd0) begin
               if (req_ff.action == ACT_DELETE) begin
                  state_in = S_DEL_RD;
               end else begin
                  state_in = S_RD_ISSUE;
               end
            end else begin
               state_in = S_WALK_WAIT;
            end
         end
         S_WALK_WAIT: begin
            cur_in   = next_val[SLOT_W-1:0];
            steps_in = steps_ff - 6'd1;
            state_in = S_WALK;
         end
         S_DEL_RD: begin
            if (count_ff == LINK_W'(1)) begin
               head_in   = NIL;
               nx_we     = 1'b1;
               free_in   = LINK_W'(cur_ff);
               count_in  = count_ff - LINK_W'(1);
               done      = 1'b1;
               done_slot = LINK_W'(cur_ff);
               state_in  = S_IDLE;
            end else begin
               state_in = S_DEL_FIX;
            end
         end
         S_DEL_FIX: begin
            nx_we    = 1'b1;
            nx_waddr = pv_rdata[SLOT_W-1:0];
            nx_wdata = next_val;
            pv_we    = 1'b1;
            pv_waddr = next_val[SLOT_W-1:0];
            pv_wdata = pv_rdata;
            if (LINK_W'(cur_ff) == head_ff) begin
               head_in = next_val;
            end
            state_in = S_DEL_FREE;
         end
         S_DEL_FREE: begin
            nx_we     = 1'b1;
            free_in   = LINK_W'(cur_ff);
            count_in  = count_ff - LINK_W'(1);
            done      = 1'b1;
            done_slot = LINK_W'(cur_ff);
            state_in  = S_IDLE;
         end
         S_RD_ISSUE: begin
            state_in = S_RD_DATA;
         end
         S_RD_DATA: begin
            done      = 1'b1;
            done_slot = LINK_W'(cur_ff);
            done_word = pay_rdata;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      nvalid_in = nvalid_ff;
      if (nx_we) begin
         nvalid_in[nx_waddr] = 1'b1;
      end
      nvld_rd_in  = nvalid_ff[nx_raddr];
      nrd_addr_in = nx_raddr;

      rsp_valid_in       = done;
      rsp_in             = rsp_ff;
      if (done) begin
         rsp_in.status    = done_status;
         rsp_in.slot      = 7'(done_slot);
         rsp_in.count     = 7'(count_in);
         rsp_in.read_word = done_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= NIL;
         free_ff      <= '0;
         count_ff     <= '0;
         fill_idx_ff  <= '0;
         fill_slot_ff <= NIL;
         nvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         fill_idx_ff  <= fill_idx_in;
         fill_slot_ff <= fill_slot_in;
         nvalid_ff    <= nvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      cur_ff      <= cur_in;
      steps_ff    <= steps_in;
      tail_ff     <= tail_in;
      nvld_rd_ff  <= nvld_rd_in;
      nrd_addr_ff <= nrd_addr_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ----- rtl/ccl_ram.sv -----
// generic single write port, single read port RAM with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ccl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
